### rtl/core/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
// No dependencies; spq_cell and the top level use this package.
package spq_pkg;

	localparam int CAPACITY = 16;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic signed [31:0] elem;
		logic signed [31:0] prio;
	} entry_t;

	// What one cell shows its two neighbors.
	typedef struct packed {
		logic   valid;
		logic   ahead;    // this cell and all cells before it stay ahead of the new entry
		entry_t ent;
	} link_t;

	// Broadcast control from the top level to every cell.
	typedef struct packed {
		logic   push;
		logic   pop;
		logic   order_mode;
		entry_t new_ent;
	} ctrl_t;

endpackage

### rtl/core/spq_if.sv
// Handshake interfaces for the request and response channels.
// Depends on nothing but plain logic types.
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic signed [31:0] elem_value;
	logic signed [31:0] priority_req;

	modport source (output valid, op, elem_value, priority_req, input ready);
	modport sink   (input valid, op, elem_value, priority_req, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_elem;
	logic signed [31:0] out_priority;
	logic [1:0]         status;
	logic               is_empty;

	modport source (output valid, out_elem, out_priority, status, is_empty, input ready);
	modport sink   (input valid, out_elem, out_priority, status, is_empty, output ready);
endinterface

### rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with a new push,
// and takes the new entry or data from its left or right neighbor. Depends on spq_pkg.
module spq_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  spq_pkg::ctrl_t ctrl,
	input  spq_pkg::link_t left,
	input  spq_pkg::link_t right,
	output spq_pkg::link_t self
);

	logic            valid_q;
	spq_pkg::entry_t ent_q;
	logic            stays;
	logic            keep_here;

	// An existing entry stays ahead when it ranks better or ties (first in, first out).
	assign stays = ctrl.order_mode ? (ent_q.prio >= ctrl.new_ent.prio)
	                               : (ent_q.prio <= ctrl.new_ent.prio);
	assign keep_here = valid_q & stays;

	assign self.valid = valid_q;
	assign self.ahead = left.ahead & keep_here;
	assign self.ent   = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.push) begin
			if (!left.ahead) begin
				valid_q <= left.valid;
			end else if (!keep_here) begin
				valid_q <= 1'b1;
			end
		end else if (ctrl.pop) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (!left.ahead) begin
				ent_q <= left.ent;
			end else if (!keep_here) begin
				ent_q <= ctrl.new_ent;
			end
		end else if (ctrl.pop) begin
			ent_q <= right.ent;
		end
	end

endmodule

### rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots,
// the order register and the response register. Depends on spq_pkg and spq_if.
//
//   channel | direction | carries
//   req     | in        | op, elem_value, priority_req
//   rsp     | out       | out_elem, out_priority, status, is_empty
//   cfg     | in        | order_mode (write enable and data)
//
// One transaction is accepted per cycle unless stalled; its response is registered.
// Every cell compares against the new priority at once; the cycle is set by the
// 32-bit compare plus the ripple of the "ahead" flag along the CAPACITY cells.
// Reset empties the queue and sets order_mode to zero.
// A waiting response stalls the request side only while rsp.ready is low.
module sorted_priority_queue (
	input logic           clk,
	input logic           arst_n,
	input logic           cfg_we,
	input logic           cfg_wdata,
	spq_req_if.sink       req,
	spq_rsp_if.source     rsp
);

	localparam int N = spq_pkg::CAPACITY;

	logic                 order_q;
	spq_pkg::link_t       link [N+2];
	spq_pkg::ctrl_t       ctrl;
	logic [N-1:0]         vld;
	logic                 accept;
	logic                 full;
	logic                 empty;

	logic                 rsp_valid_q;
	logic signed [31:0]   rsp_elem_q;
	logic signed [31:0]   rsp_prio_q;
	logic [1:0]           rsp_status_q;
	logic                 rsp_empty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
		end else if (cfg_we) begin
			order_q <= cfg_wdata;
		end
	end

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// link[0] is a fixed head boundary, link[N+1] a fixed empty tail.
	assign link[0]   = '{valid: 1'b1, ahead: 1'b1, ent: '0};
	assign link[N+1] = '{valid: 1'b0, ahead: 1'b0, ent: '0};

	assign full  = link[N].valid;
	assign empty = !link[1].valid;

	assign ctrl.push       = accept && (req.op == spq_pkg::OP_PUSH) && !full;
	assign ctrl.pop        = accept && (req.op == spq_pkg::OP_POP) && !empty;
	assign ctrl.order_mode = order_q;
	assign ctrl.new_ent    = '{elem: req.elem_value, prio: req.priority_req};

	for (genvar i = 1; i <= N; i++) begin : g_cell
		spq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (link[i-1]),
			.right  (link[i+1]),
			.self   (link[i])
		);
		assign vld[i-1] = link[i].valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (req.op)
				spq_pkg::OP_PUSH: begin
					rsp_elem_q   <= '0;
					rsp_prio_q   <= '0;
					rsp_status_q <= full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
					rsp_empty_q  <= 1'b0;
				end
				spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
					if (empty) begin
						rsp_elem_q   <= '0;
						rsp_prio_q   <= '0;
						rsp_status_q <= spq_pkg::ST_EMPTY;
						rsp_empty_q  <= 1'b1;
					end else begin
						rsp_elem_q   <= link[1].ent.elem;
						rsp_prio_q   <= link[1].ent.prio;
						rsp_status_q <= spq_pkg::ST_OK;
						// A pop empties the queue when only the head was valid.
						rsp_empty_q  <= (req.op == spq_pkg::OP_POP) ? !link[2].valid : 1'b0;
					end
				end
				default: begin
					rsp_elem_q   <= '0;
					rsp_prio_q   <= '0;
					rsp_status_q <= spq_pkg::ST_OK;
					rsp_empty_q  <= empty;
				end
			endcase
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.out_elem     = rsp_elem_q;
	assign rsp.out_priority = rsp_prio_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.is_empty     = rsp_empty_q;

`ifndef SYNTHESIS
	a_prefix_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, vld} + {{N{1'b0}}, 1'b1}))
		else $error("valid cells do not form a contiguous prefix");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> $countones(vld) == $past($countones(vld)) + 1)
		else $error("successful push did not add exactly one entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> $countones(vld) + 1 == $past($countones(vld)))
		else $error("successful pop did not remove exactly one entry");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q == spq_pkg::ST_EMPTY) |->
		(rsp_elem_q == '0 && rsp_prio_q == '0 && rsp_empty_q))
		else $error("empty response carries data or a wrong empty flag");
`endif

endmodule
